// ===== design/idq_pkg.sv =====
// ----------------------------------------------------------------------------
// idq_pkg
// Shared types and constants for the indexed deque store: operation and
// status codes, store geometry and the command broadcast to the cell row.
// ----------------------------------------------------------------------------
package idq_pkg;

   localparam int CAPACITY  = 16;
   localparam int ADDR_W    = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int OP_W      = 4;
   localparam int IDX_W     = 5;
   localparam int DATA_W    = 32;
   localparam int ST_W      = 2;
   localparam int CNT_OUT_W = 5;
   localparam int POS_W     = (CNT_W > IDX_W) ? CNT_W : IDX_W;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 4'd0,
      OP_PUSH_BACK  = 4'd1,
      OP_POP_FRONT  = 4'd2,
      OP_POP_BACK   = 4'd3,
      OP_INSERT     = 4'd4,
      OP_REMOVE     = 4'd5,
      OP_READ_AT    = 4'd6,
      OP_PEEK_FRONT = 4'd7,
      OP_PEEK_BACK  = 4'd8,
      OP_CLEAR      = 4'd9
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Broadcast to every cell: open a gap at pos, or close the gap at pos.
   typedef struct packed {
      logic              ins;
      logic              rem;
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] value;
   } cell_cmd_type;

   // Outcome of one request as seen by the response side.
   typedef struct packed {
      logic             rd;
      status_type       status;
      logic [CNT_W-1:0] count_next;
   } ctrl_res_type;

endpackage

// ===== design/indexed_deque_store.sv =====
// ----------------------------------------------------------------------------
// indexed_deque_store
// Bounded ordered store of signed 32-bit values held in a row of cells.
// ----------------------------------------------------------------------------
// Response: registered; the response word appears in the cycle after the request word is taken.
// Throughput: one request per cycle while the response side drains; every cell shifts in the same cycle,
//   so insert and remove finish in one step of the cell row.
// Reset: clears the entry count and the response valid; the cells keep
//   their contents, and only entries below the count are ever read.
// ----------------------------------------------------------------------------
module indexed_deque_store (
   input  logic        clock,
   input  logic        reset,
   // request word
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [3:0] operation, [8:4] index, [40:9] value, rest zero
   // response word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [31:0] data, [33:32] status, [38:34] count,
                                    // [39] empty_res
);

   localparam int OP_LO  = 0;
   localparam int IDX_LO = OP_LO + idq_pkg::OP_W;
   localparam int VAL_LO = IDX_LO + idq_pkg::IDX_W;

   logic                          fire;
   logic [idq_pkg::CNT_W-1:0]     count_ff;
   logic [idq_pkg::CNT_W-1:0]     count_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [idq_pkg::DATA_W-1:0]    rsp_data_ff;
   logic [idq_pkg::DATA_W-1:0]    rsp_data_in;
   idq_pkg::status_type           rsp_status_ff;
   logic [idq_pkg::CNT_OUT_W-1:0] rsp_count_ff;
   logic                          rsp_empty_ff;
   idq_pkg::cell_cmd_type         cmd;
   idq_pkg::ctrl_res_type         res;
   logic [idq_pkg::DATA_W-1:0]    entry_q [idq_pkg::CAPACITY];

   // Take a new word whenever the response slot is free or drains now.
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign fire       = req_tvalid & req_tready;

   idq_ctrl u_ctrl (
      .fire  (fire),
      .op    (idq_pkg::op_type'(req_tdata[IDX_LO-1:OP_LO])),
      .index (req_tdata[VAL_LO-1:IDX_LO]),
      .value (req_tdata[VAL_LO+idq_pkg::DATA_W-1:VAL_LO]),
      .count (count_ff),
      .cmd   (cmd),
      .res   (res)
   );

   // Cell row: each cell sees its left and right neighbor. The ends see
   // the new word and zero; the first cell never selects its left input, and the last takes zero on a remove.
   for (genvar i = 0; i < idq_pkg::CAPACITY; i++) begin : g_cell
      logic [idq_pkg::DATA_W-1:0] left_entry;
      logic [idq_pkg::DATA_W-1:0] right_entry;

      if (i == 0) begin : g_first
         assign left_entry = cmd.value;
      end else begin : g_mid_l
         assign left_entry = entry_q[i-1];
      end

      if (i == idq_pkg::CAPACITY - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_mid_r
         assign right_entry = entry_q[i+1];
      end

      idq_cell u_cell (
         .clock       (clock),
         .slot        (idq_pkg::POS_W'(i)),
         .cmd         (cmd),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (entry_q[i])
      );
   end

   // Read the addressed cell before the row shifts; errors, writes, clears and ignored codes give 0.
   always_comb begin
      count_in     = fire ? res.count_next : count_ff;
      rsp_valid_in = fire | (rsp_valid_ff & ~rsp_tready);
      rsp_data_in  = res.rd ? entry_q[cmd.pos[idq_pkg::ADDR_W-1:0]] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the response payload until the next accepted request.
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= res.status;
         rsp_count_ff  <= idq_pkg::CNT_OUT_W'(res.count_next);
         rsp_empty_ff  <= (res.count_next == '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_empty_ff, rsp_count_ff, rsp_status_ff, rsp_data_ff};

endmodule

// ===== design/idq_cell.sv =====
// ----------------------------------------------------------------------------
// idq_cell
// One storage slot of the row. Holds one entry and, on insert or remove,
// takes the new word, its left neighbor or its right neighbor.
// ----------------------------------------------------------------------------
module idq_cell (
   input  logic                         clock,
   input  logic [idq_pkg::POS_W-1:0]    slot,
   input  idq_pkg::cell_cmd_type        cmd,
   input  logic [idq_pkg::DATA_W-1:0]   left_entry,
   input  logic [idq_pkg::DATA_W-1:0]   right_entry,
   output logic [idq_pkg::DATA_W-1:0]   entry
);

   logic [idq_pkg::DATA_W-1:0] entry_ff;
   logic [idq_pkg::DATA_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins && slot == cmd.pos) begin
         entry_in = cmd.value;
      end else if (cmd.ins && slot > cmd.pos) begin
         entry_in = left_entry;
      end else if (cmd.rem && slot >= cmd.pos) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== design/idq_ctrl.sv =====
// ----------------------------------------------------------------------------
// idq_ctrl
// Request decoder: picks the position, runs the range and full checks,
// and builds the row command and the next entry count.
// ----------------------------------------------------------------------------
module idq_ctrl (
   input  logic                         fire,
   input  idq_pkg::op_type              op,
   input  logic [idq_pkg::IDX_W-1:0]    index,
   input  logic [idq_pkg::DATA_W-1:0]   value,
   input  logic [idq_pkg::CNT_W-1:0]    count,
   output idq_pkg::cell_cmd_type        cmd,
   output idq_pkg::ctrl_res_type        res
);

   logic [idq_pkg::POS_W-1:0] cnt_w;
   logic [idq_pkg::POS_W-1:0] last;
   logic [idq_pkg::POS_W-1:0] pos;
   logic                      is_ins;
   logic                      is_fetch;
   logic                      take;
   logic                      clr;
   logic                      ok;

   always_comb begin
      cnt_w    = idq_pkg::POS_W'(count);
      last     = cnt_w - idq_pkg::POS_W'(1);
      pos      = '0;
      is_ins   = 1'b0;
      is_fetch = 1'b0;
      take     = 1'b0;
      clr      = 1'b0;

      unique case (op)
         idq_pkg::OP_PUSH_FRONT: begin
            is_ins = 1'b1;
         end
         idq_pkg::OP_PUSH_BACK: begin
            is_ins = 1'b1;
            pos    = cnt_w;
         end
         idq_pkg::OP_INSERT: begin
            is_ins = 1'b1;
            pos    = idq_pkg::POS_W'(index);
         end
         idq_pkg::OP_POP_FRONT: begin
            is_fetch = 1'b1;
            take     = 1'b1;
         end
         idq_pkg::OP_POP_BACK: begin
            is_fetch = 1'b1;
            take     = 1'b1;
            pos      = last;
         end
         idq_pkg::OP_REMOVE: begin
            is_fetch = 1'b1;
            take     = 1'b1;
            pos      = idq_pkg::POS_W'(index);
         end
         idq_pkg::OP_READ_AT: begin
            is_fetch = 1'b1;
            pos      = idq_pkg::POS_W'(index);
         end
         idq_pkg::OP_PEEK_FRONT: begin
            is_fetch = 1'b1;
         end
         idq_pkg::OP_PEEK_BACK: begin
            is_fetch = 1'b1;
            pos      = last;
         end
         idq_pkg::OP_CLEAR: begin
            clr = 1'b1;
         end
         default: begin
         end
      endcase

      // Range test goes before the full test. An empty store makes last
      // wrap to all ones, which the fetch range test rejects.
      res.status = idq_pkg::ST_OK;
      ok         = 1'b0;
      if (is_ins) begin
         if (pos > cnt_w) begin
            res.status = idq_pkg::ST_RANGE;
         end else if (count >= idq_pkg::CNT_W'(idq_pkg::CAPACITY)) begin
            res.status = idq_pkg::ST_FULL;
         end else begin
            ok = 1'b1;
         end
      end else if (is_fetch) begin
         if (pos >= cnt_w) begin
            res.status = idq_pkg::ST_RANGE;
         end else begin
            ok = 1'b1;
         end
      end

      res.rd = is_fetch & ok;
      if (clr) begin
         res.count_next = '0;
      end else if (is_ins && ok) begin
         res.count_next = count + idq_pkg::CNT_W'(1);
      end else if (take && ok) begin
         res.count_next = count - idq_pkg::CNT_W'(1);
      end else begin
         res.count_next = count;
      end

      cmd.ins   = fire & is_ins & ok;
      cmd.rem   = fire & take & ok;
      cmd.pos   = pos;
      cmd.value = value;
   end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for indexed_deque_store. A queued driver offers
// request words with random gaps, a monitor predicts every response from its
// own copy of the store, and a receiver stalls the response side at random.
// ----------------------------------------------------------------------------
module testbench;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 4;
   localparam int RANDOM_ITEMS = 550;
   localparam int BLOCK_ITEMS  = 50;
   localparam int LONG_HOLD    = 200;
   localparam int HOLD_AFTER   = 150;
   localparam int DRAIN_CYCLES = 10;
   localparam int TIMEOUT_NS   = 2000000;

   // Operation codes the block must ignore.
   localparam logic [idq_pkg::OP_W-1:0] FIRST_UNUSED_OP = 4'd10;
   localparam logic [idq_pkg::OP_W-1:0] LAST_UNUSED_OP  = 4'd15;

   typedef enum int {MODE_GROW, MODE_MIXED, MODE_SHRINK} fill_mode_type;

   typedef struct {
      logic [idq_pkg::OP_W-1:0]   op;
      logic [idq_pkg::IDX_W-1:0]  idx;
      logic [idq_pkg::DATA_W-1:0] val;
      int                         gap;     // cycles to idle before offering the word
      bit                         settle;  // wait until every response is back
   } req_item_type;

   typedef struct {
      logic [idq_pkg::DATA_W-1:0]    data;
      idq_pkg::status_type           status;
      logic [idq_pkg::CNT_OUT_W-1:0] count;
      logic                          empty;
   } reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // [3:0] operation, [8:4] index, [40:9] value, rest zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // [31:0] data, [33:32] status, [38:34] count,
                                  // [39] empty_res

   req_item_type pending_requests [$];
   reply_type    expected_replies [$];

   // Predicted store contents; entries at or above store_fill are never read.
   logic [idq_pkg::DATA_W-1:0] store_mem [idq_pkg::CAPACITY];
   int                         store_fill = 0;

   int  mismatch_count = 0;
   int  replies_seen = 0;
   bit  req_fire = 1'b0;
   bit  rsp_fire = 1'b0;
   bit  armed = 1'b0;
   req_item_type current_item;
   int  gap_left = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   bit  long_hold_done = 1'b0;

   indexed_deque_store i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // Hold reset for a few cycles, release it on a falling edge.
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("indexed_deque_store regression: fail");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Apply one request to the predicted store and return the response it
   // should produce. Range test comes before the full test on writes.
   function automatic reply_type apply_request(logic [idq_pkg::OP_W-1:0] op,
                                               logic [idq_pkg::IDX_W-1:0] idx,
                                               logic [idq_pkg::DATA_W-1:0] val);
      reply_type r;
      int        pos;
      bit        put;
      bit        fetch;
      bit        take;
      r.data   = '0;
      r.status = idq_pkg::ST_OK;
      put   = 1'b0;
      fetch = 1'b0;
      take  = 1'b0;
      pos   = 0;
      case (op)
         idq_pkg::OP_PUSH_FRONT: begin put = 1'b1; pos = 0; end
         idq_pkg::OP_PUSH_BACK:  begin put = 1'b1; pos = store_fill; end
         idq_pkg::OP_POP_FRONT:  begin fetch = 1'b1; take = 1'b1; pos = 0; end
         idq_pkg::OP_POP_BACK:   begin fetch = 1'b1; take = 1'b1; pos = store_fill - 1; end
         idq_pkg::OP_INSERT:     begin put = 1'b1; pos = idx; end
         idq_pkg::OP_REMOVE:     begin fetch = 1'b1; take = 1'b1; pos = idx; end
         idq_pkg::OP_READ_AT:    begin fetch = 1'b1; pos = idx; end
         idq_pkg::OP_PEEK_FRONT: begin fetch = 1'b1; pos = 0; end
         idq_pkg::OP_PEEK_BACK:  begin fetch = 1'b1; pos = store_fill - 1; end
         idq_pkg::OP_CLEAR:      store_fill = 0;
         default: ;
      endcase
      if (put) begin
         if (pos > store_fill) begin
            r.status = idq_pkg::ST_RANGE;
         end else if (store_fill >= idq_pkg::CAPACITY) begin
            r.status = idq_pkg::ST_FULL;
         end else begin
            for (int k = store_fill; k > pos; k--) store_mem[k] = store_mem[k-1];
            store_mem[pos] = val;
            store_fill++;
         end
      end
      if (fetch) begin
         if (pos < 0 || pos >= store_fill) begin
            r.status = idq_pkg::ST_RANGE;
         end else begin
            r.data = store_mem[pos];
            if (take) begin
               for (int k = pos; k + 1 < store_fill; k++) store_mem[k] = store_mem[k+1];
               store_fill--;
            end
         end
      end
      r.count = store_fill[idq_pkg::CNT_OUT_W-1:0];
      r.empty = (store_fill == 0);
      return r;
   endfunction

   task automatic add_request(input logic [idq_pkg::OP_W-1:0] op,
                              input logic [idq_pkg::IDX_W-1:0] idx,
                              input logic [idq_pkg::DATA_W-1:0] val, input int gap,
                              input bit settle);
      req_item_type item;
      item.op     = op;
      item.idx    = idx;
      item.val    = val;
      item.gap    = gap;
      item.settle = settle;
      pending_requests.push_back(item);
   endtask

   // Weighted operation choice; the last bucket is the ignored codes.
   function automatic logic [idq_pkg::OP_W-1:0] pick_operation(fill_mode_type mode);
      logic [idq_pkg::OP_W-1:0] menu [10];
      int weight [11];
      int roll;
      menu = '{idq_pkg::OP_PUSH_FRONT, idq_pkg::OP_PUSH_BACK, idq_pkg::OP_POP_FRONT,
               idq_pkg::OP_POP_BACK, idq_pkg::OP_INSERT, idq_pkg::OP_REMOVE,
               idq_pkg::OP_READ_AT, idq_pkg::OP_PEEK_FRONT, idq_pkg::OP_PEEK_BACK,
               idq_pkg::OP_CLEAR};
      case (mode)
         MODE_GROW:   weight = '{22, 22, 6, 4, 22, 4, 8, 4, 4, 1, 3};
         MODE_SHRINK: weight = '{4, 4, 22, 22, 4, 20, 8, 4, 4, 2, 6};
         default:     weight = '{10, 10, 10, 10, 12, 10, 14, 7, 7, 2, 8};
      endcase
      roll = $urandom_range(0, 99);
      for (int k = 0; k < 10; k++) begin
         if (roll < weight[k]) return menu[k];
         roll -= weight[k];
      end
      return FIRST_UNUSED_OP + 4'($urandom_range(0, LAST_UNUSED_OP - FIRST_UNUSED_OP));
   endfunction

   function automatic logic [idq_pkg::IDX_W-1:0] pick_index();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 75) return idq_pkg::IDX_W'($urandom_range(0, idq_pkg::CAPACITY));
      if (roll < 90) return idq_pkg::IDX_W'($urandom_range(0, 3));
      return idq_pkg::IDX_W'($urandom_range(0, (1 << idq_pkg::IDX_W) - 1));
   endfunction

   function automatic logic [idq_pkg::DATA_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 9);
      case (roll)
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // Stimulus: directed corners, then blocks that push the fill level up,
   // churn it, and drain it again. Then wait for the run to settle.
   initial begin
      int blk;
      int gap;
      // empty store: every read or removal is out of range
      add_request(idq_pkg::OP_POP_FRONT,  5'd0,  32'h1234_5678, $urandom_range(0, 10), 1'b0);
      add_request(idq_pkg::OP_POP_BACK,   5'd0,  32'h0,         $urandom_range(0, 10), 1'b0);
      add_request(idq_pkg::OP_PEEK_FRONT, 5'd0,  32'h0,         $urandom_range(0, 10), 1'b0);
      add_request(idq_pkg::OP_PEEK_BACK,  5'd0,  32'h0,         $urandom_range(0, 10), 1'b0);
      add_request(idq_pkg::OP_READ_AT,    5'd0,  32'h0,         $urandom_range(0, 10), 1'b0);
      add_request(idq_pkg::OP_REMOVE,     5'd0,  32'h0,         $urandom_range(0, 10), 1'b0);
      // insert past the count, then insert at the count (append)
      add_request(idq_pkg::OP_INSERT,     5'd1,  32'hdead_beef, $urandom_range(0, 10), 1'b0);
      add_request(idq_pkg::OP_INSERT,     5'd0,  32'h8000_0000, $urandom_range(0, 10), 1'b0);
      add_request(idq_pkg::OP_PUSH_BACK,  5'd31, 32'h7fff_ffff, $urandom_range(0, 10), 1'b0);
      add_request(idq_pkg::OP_PUSH_FRONT, 5'd16, 32'hffff_ffff, $urandom_range(0, 10), 1'b0);
      add_request(idq_pkg::OP_PUSH_FRONT, 5'd0,  32'h0000_0000, $urandom_range(0, 10), 1'b0);
      add_request(idq_pkg::OP_INSERT,     5'd2,  32'h5a5a_a5a5, $urandom_range(0, 10), 1'b0);
      add_request(idq_pkg::OP_INSERT,     5'd5,  32'h0f0f_f0f0, $urandom_range(0, 10), 1'b0);
      add_request(idq_pkg::OP_INSERT,     5'd31, 32'h1111_1111, $urandom_range(0, 10), 1'b0);
      add_request(idq_pkg::OP_READ_AT,    5'd3,  32'h0,         $urandom_range(0, 10), 1'b0);
      add_request(idq_pkg::OP_READ_AT,    5'd31, 32'h0,         $urandom_range(0, 10), 1'b0);
      // removal at the count is out of range
      add_request(idq_pkg::OP_REMOVE,     5'd6,  32'h0,         $urandom_range(0, 10), 1'b0);
      add_request(idq_pkg::OP_REMOVE,     5'd2,  32'h0,         $urandom_range(0, 10), 1'b0);
      add_request(idq_pkg::OP_PEEK_FRONT, 5'd0,  32'h0,         $urandom_range(0, 10), 1'b0);
      add_request(idq_pkg::OP_PEEK_BACK,  5'd0,  32'h0,         $urandom_range(0, 10), 1'b0);
      // ignored codes leave the store alone
      add_request(FIRST_UNUSED_OP,        5'd0,  32'hffff_ffff, $urandom_range(0, 10), 1'b0);
      add_request(LAST_UNUSED_OP,         5'd31, 32'hffff_ffff, $urandom_range(0, 10), 1'b0);
      add_request(idq_pkg::OP_POP_BACK,   5'd0,  32'h0,         $urandom_range(0, 10), 1'b0);
      add_request(idq_pkg::OP_POP_FRONT,  5'd0,  32'h0,         $urandom_range(0, 10), 1'b0);
      add_request(idq_pkg::OP_CLEAR,      5'd0,  32'h0,         $urandom_range(0, 10), 1'b0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         blk = n / BLOCK_ITEMS;
         // every fourth block runs back to back
         gap = (blk % 4 == 2) ? 0 : $urandom_range(0, 10);
         add_request(pick_operation(fill_mode_type'(blk % 3)), pick_index(), pick_value(),
                     gap, (n % BLOCK_ITEMS == 0) && (blk % 4 != 2));
      end

      while (pending_requests.size() > 0 || armed || req_tvalid) @(posedge clock);
      while (expected_replies.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("indexed_deque_store regression: pass");
      end else begin
         $display("indexed_deque_store regression: fail");
      end
      $finish;
   end

   // Driver: hold a word until it is taken, then idle for the next item's
   // gap, and for a settle item wait until every response is back.
   always @(negedge clock) begin : driver
      bit next_valid;
      next_valid = 1'b0;
      if (!reset) begin
         if (req_tvalid && !req_fire) begin
            next_valid = 1'b1;
         end else begin
            if (req_fire) armed = 1'b0;
            if (!armed && pending_requests.size() > 0) begin
               current_item = pending_requests.pop_front();
               gap_left = current_item.gap;
               armed = 1'b1;
            end
            if (armed) begin
               if (gap_left > 0) begin
                  gap_left--;
               end else if (!current_item.settle || expected_replies.size() == 0) begin
                  req_tdata <= {7'b0, current_item.val, current_item.idx, current_item.op};
                  next_valid = 1'b1;
               end
            end
         end
      end
      req_tvalid <= next_valid;
   end

   // Receiver: after each word taken, drop ready for a random stall. Once,
   // hold off for a long stretch so the block backs up into its input.
   always @(negedge clock) begin : receiver
      bit next_ready;
      next_ready = 1'b0;
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left--;
         end else if (!long_hold_done && replies_seen >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
         end else if (rsp_fire) begin
            stall_left = ((replies_seen / 100) % 4 == 2) ? 0 : $urandom_range(0, 10);
            next_ready = (stall_left == 0);
         end else if (stall_left > 0) begin
            stall_left--;
            next_ready = (stall_left == 0);
         end else begin
            next_ready = 1'b1;
         end
      end
      rsp_tready <= next_ready;
   end

   // Monitor: check the response word first (it belongs to an earlier
   // request), then predict the request taken at this edge.
   always @(posedge clock) begin : monitor
      reply_type want;
      req_fire = 1'b0;
      rsp_fire = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_fire = 1'b1;
            replies_seen++;
            if (expected_replies.size() == 0) begin
               report_mismatch($sformatf("response word 0x%h with nothing pending", rsp_tdata));
            end else begin
               want = expected_replies.pop_front();
               if (rsp_tdata[31:0] !== want.data)
                  report_mismatch($sformatf("data 0x%h, predicted 0x%h",
                                            rsp_tdata[31:0], want.data));
               if (rsp_tdata[33:32] !== want.status)
                  report_mismatch($sformatf("status %0d, predicted %0d",
                                            rsp_tdata[33:32], want.status));
               if (rsp_tdata[38:34] !== want.count)
                  report_mismatch($sformatf("count %0d, predicted %0d",
                                            rsp_tdata[38:34], want.count));
               if (rsp_tdata[39] !== want.empty)
                  report_mismatch($sformatf("empty_res %0b, predicted %0b",
                                            rsp_tdata[39], want.empty));
            end
         end
         if (req_tvalid && req_tready) begin
            req_fire = 1'b1;
            expected_replies.push_back(apply_request(req_tdata[3:0], req_tdata[8:4],
                                                     req_tdata[40:9]));
         end
      end
   end

endmodule

// ===== files.f =====
design/idq_pkg.sv
design/idq_cell.sv
design/idq_ctrl.sv
design/indexed_deque_store.sv
test/testbench.sv
